>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define MCPTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that b holds in the cycle after a.
`define MCPTD_ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

>>> sv/mcptd_pkg.sv
package mcptd_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [15:0] PERIOD_CAP = 16'd3000;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ADD  = 2'd1,
    OP_DEL  = 2'd2,
    OP_SET  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_FIRED    = 2'd0,
    ST_DONE     = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_HOLD = 3'd0,
    CMD_ROT  = 3'd1,
    CMD_ADD  = 3'd2,
    CMD_DEL  = 3'd3,
    CMD_SET  = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    logic [15:0] owner;
    logic [15:0] period;
    logic        enabled;
    logic        pending;
  } entry_t;

  typedef struct packed {
    cell_cmd_t        cmd;
    logic [IDX_W-1:0] sel;
    logic [CNT_W-1:0] count;
    logic [15:0]      id;
    logic             act;
    entry_t           new_ent;
  } cell_ctl_t;

endpackage

>>> sv/mcptd_cell.sv
module mcptd_cell (
  input  logic                       clk,
  input  mcptd_pkg::cell_ctl_t       ctl,
  input  logic [mcptd_pkg::IDX_W-1:0] idx,
  input  mcptd_pkg::entry_t          next_in,
  output mcptd_pkg::entry_t          ent,
  output logic                       match
);
  import mcptd_pkg::*;

  logic [CNT_W-1:0] pos;

  assign pos = CNT_W'(idx);
  assign match = (ent.owner == ctl.id) && (pos < ctl.count);

  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      CMD_ROT: ent <= next_in;
      CMD_ADD: begin
        if (pos == ctl.count) ent <= ctl.new_ent;
      end
      CMD_DEL: begin
        if (idx >= ctl.sel) ent <= next_in;
      end
      CMD_SET: begin
        if (idx == ctl.sel) ent.enabled <= ctl.act;
      end
      default: ent <= ent;
    endcase
  end

endmodule

>>> sv/mcptd_mod.sv
module mcptd_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] rem
);
  import mcptd_pkg::*;

  logic [31:0] quo;
  logic [5:0]  cnt;
  logic [16:0] trial;

  assign trial = {rem, quo[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= 6'd32;
        quo <= dividend;
        rem <= '0;
      end else if (cnt != 6'd0) begin
        if (trial >= {1'b0, divisor}) begin
          rem <= 16'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[15:0];
        end
        quo <= {quo[30:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) done <= 1'b1;
      end
    end
  end

  `include "assert_macros.svh"
  `MCPTD_ASSERT(a_done_after_last_step, !done || $past(cnt) == 6'd1, "done without last step")
  `MCPTD_ASSERT_NEXT(a_start_loads, start, cnt == 6'd32, "start did not load counter")
  `MCPTD_ASSERT(a_rem_below_divisor, !done || rem < divisor, "remainder not reduced")

endmodule

>>> sv/multi_channel_periodic_tick_dispatcher_core.sv
// Channel  | Handshake            | Payload
// input    | in_valid / in_stall  | op, object_id, period, immediate, active
// output   | out_valid / out_stall| owner_id, status, last
// config   | cap_enable_we        | cap_enable_wdata
// Add, remove and set are accepted in idle; their result word is registered and presented on the output.
// A tick runs the 32-step serial modulo for each active channel with a nonzero
// period that is not pending.
// Reset clears the tick counter, the channel count and the control state.
// A stalled output holds the scan until the word is taken.
module multi_channel_periodic_tick_dispatcher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cap_enable_we,
  input  logic        cap_enable_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [15:0] object_id,
  input  logic [15:0] period,
  input  logic        immediate,
  input  logic        active,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] owner_id,
  output logic [1:0]  status,
  output logic        last
);
  import mcptd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_MOD  = 4'b0100,
    S_STEP = 4'b1000
  } state_t;

  state_t           state;
  logic             cap_enable;
  logic [31:0]      tick_counter;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] step;
  logic             fire_now;
  logic             have_held;
  logic [15:0]      held_id;

  entry_t           ents [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] hits;
  entry_t           head;
  entry_t           ret_ent;
  cell_ctl_t        ctl;

  logic             found;
  logic [IDX_W-1:0] found_idx;
  logic             in_acc;
  logic             slot_free;
  logic             out_load;
  logic             live;
  logic             need_mod;
  logic             mod_start;
  logic             mod_done;
  logic [15:0]      mod_rem;
  logic [15:0]      per_eff;

  assign head = ents[0];
  assign in_stall = (state != S_IDLE) || out_valid;
  assign in_acc = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign out_load = slot_free && have_held &&
                    (((state == S_SCAN) && (step == CNT_W'(MAX_ENTRIES))) ||
                     ((state == S_STEP) && fire_now));
  assign live = (step < count) && head.enabled;
  assign need_mod = live && !head.pending && (head.period != 16'd0);
  assign mod_start = (state == S_SCAN) && (step != CNT_W'(MAX_ENTRIES)) && need_mod;
  assign per_eff = (cap_enable && (period > PERIOD_CAP)) ? PERIOD_CAP : period;

  always_comb begin
    ret_ent = head;
    ret_ent.pending = head.pending && !fire_now;
  end

  always_comb begin
    found = 1'b0;
    found_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (hits[i]) begin
        found = 1'b1;
        found_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    ctl.cmd = CMD_HOLD;
    ctl.sel = found_idx;
    ctl.count = count;
    ctl.id = object_id;
    ctl.act = active;
    ctl.new_ent.owner = object_id;
    ctl.new_ent.period = per_eff;
    ctl.new_ent.enabled = 1'b1;
    ctl.new_ent.pending = immediate;
    if (in_acc) begin
      unique case (op_t'(op))
        OP_ADD: begin
          if (count != CNT_W'(MAX_ENTRIES)) ctl.cmd = CMD_ADD;
        end
        OP_DEL: begin
          if (found) ctl.cmd = CMD_DEL;
        end
        OP_SET: begin
          if (found) ctl.cmd = CMD_SET;
        end
        default: ctl.cmd = CMD_HOLD;
      endcase
    end else if (state == S_STEP && (!(fire_now && have_held) || slot_free)) begin
      ctl.cmd = CMD_ROT;
    end
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    entry_t nxt;
    if (g == MAX_ENTRIES - 1) begin : g_tail
      assign nxt = ret_ent;
    end else begin : g_mid
      assign nxt = ents[g+1];
    end
    mcptd_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .idx     (IDX_W'(g)),
      .next_in (nxt),
      .ent     (ents[g]),
      .match   (hits[g])
    );
  end

  mcptd_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (tick_counter),
    .divisor  (head.period),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cap_enable   <= 1'b0;
      tick_counter <= '0;
      count        <= '0;
      step         <= '0;
      have_held    <= 1'b0;
      out_valid    <= 1'b0;
      fire_now     <= 1'b0;
    end else begin
      if (cap_enable_we) cap_enable <= cap_enable_wdata;
      if (out_valid && !out_stall && !out_load) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            owner_id  <= object_id;
            last      <= 1'b1;
            unique case (op_t'(op))
              OP_TICK: begin
                tick_counter <= tick_counter + 32'd1;
                step         <= '0;
                have_held    <= 1'b0;
                state        <= S_SCAN;
              end
              OP_ADD: begin
                out_valid <= 1'b1;
                if (count == CNT_W'(MAX_ENTRIES)) begin
                  status <= ST_FULL;
                end else begin
                  status <= ST_DONE;
                  count  <= count + CNT_W'(1);
                end
              end
              OP_DEL: begin
                out_valid <= 1'b1;
                status    <= found ? ST_DONE : ST_NOTFOUND;
                if (found) count <= count - CNT_W'(1);
              end
              default: begin
                out_valid <= 1'b1;
                status    <= found ? ST_DONE : ST_NOTFOUND;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (step == CNT_W'(MAX_ENTRIES)) begin
            if (!have_held) begin
              state <= S_IDLE;
            end else if (slot_free) begin
              out_valid <= 1'b1;
              owner_id  <= held_id;
              status    <= ST_FIRED;
              last      <= 1'b1;
              have_held <= 1'b0;
              state     <= S_IDLE;
            end
          end else if (need_mod) begin
            state <= S_MOD;
          end else begin
            fire_now <= live && head.pending;
            state    <= S_STEP;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            fire_now <= (mod_rem == 16'd0);
            state    <= S_STEP;
          end
        end
        S_STEP: begin
          if (!(fire_now && have_held) || slot_free) begin
            if (fire_now) begin
              if (have_held) begin
                out_valid <= 1'b1;
                owner_id  <= held_id;
                status    <= ST_FIRED;
                last      <= 1'b0;
              end
              held_id   <= head.owner;
              have_held <= 1'b1;
            end
            step  <= step + CNT_W'(1);
            state <= S_SCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `MCPTD_ASSERT(a_count_bound, count <= CNT_W'(MAX_ENTRIES), "channel count beyond table")
  `MCPTD_ASSERT(a_mod_done_in_mod, !mod_done || state == S_MOD, "modulo result outside wait")
  `MCPTD_ASSERT_NEXT(a_tick_scans, in_acc && op == OP_TICK, state == S_SCAN, "tick lost")

endmodule
